/* sv/cdmac_pkg.sv */
package cdmac_pkg;

    // Channel count the block is normally built with, and the most it may take
    localparam int unsigned NUM_CHANNELS_DEF = 10;
    localparam int unsigned NUM_BASES        = 10;
    localparam int unsigned GLOBAL_REGS      = 7;

    // Address bits 15..8 that select channels 0..9
    localparam logic [7:0] CHAN_BASE [NUM_BASES] = '{
        8'h80, 8'h90, 8'hA0, 8'hB0, 8'hB4,
        8'hC0, 8'hC4, 8'hC8, 8'hD0, 8'hD4
    };

    // Full addresses of the plain global registers
    localparam logic [31:0] GLOBAL_ADDR [GLOBAL_REGS] = '{
        32'h1000_E000, 32'h1000_E020, 32'h1000_E030, 32'h1000_E040,
        32'h1000_E050, 32'h1000_F520, 32'h1000_F590
    };

    localparam logic [31:0] STAT_ADDR   = 32'h1000_E010;
    localparam logic [31:0] FLAG_MASK   = 32'h0000_03FF;
    localparam logic [31:0] MASK_FIELD  = 32'h03FF_0000;
    localparam logic [31:0] STAT_KEEP   = 32'h03FF_03FF;
    localparam logic [31:0] TAG_STEP    = 32'd16;
    localparam int unsigned TIE_BIT_POS = 7;

    // Channel register offsets (address bits 7..0)
    localparam logic [7:0] OFS_CONTROL  = 8'h00;
    localparam logic [7:0] OFS_MEM_ADDR = 8'h10;
    localparam logic [7:0] OFS_COUNT    = 8'h20;
    localparam logic [7:0] OFS_TAG_PTR  = 8'h30;
    localparam logic [7:0] OFS_STACK0   = 8'h40;
    localparam logic [7:0] OFS_STACK1   = 8'h50;
    localparam logic [7:0] OFS_SPAD     = 8'h80;

    // Chain tag ids
    localparam logic [2:0] TAG_REF_END = 3'd0;
    localparam logic [2:0] TAG_CNT     = 3'd1;
    localparam logic [2:0] TAG_NEXT    = 3'd2;
    localparam logic [2:0] TAG_REF     = 3'd3;
    localparam logic [2:0] TAG_END     = 3'd7;

    typedef enum logic [1:0] {
        FN_READ    = 2'd0,
        FN_WRITE   = 2'd1,
        FN_SRC_TAG = 2'd2,
        FN_DST_TAG = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CR_CONTROL,
        CR_MEM_ADDR,
        CR_COUNT,
        CR_TAG_PTR,
        CR_STACK0,
        CR_STACK1,
        CR_SPAD,
        CR_NONE
    } t_chan_reg;

    typedef struct packed {
        logic      chan_hit;
        t_chan_reg reg_sel;
        logic      glob_hit;
        logic [2:0] glob_idx;
        logic      stat_hit;
    } t_dec;

endpackage

/* sv/cdmac_decode.sv */
module cdmac_decode #(
    parameter int unsigned NumChannels = cdmac_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned ChW         = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
    input  logic [31:0]       i_addr,
    output cdmac_pkg::t_dec   o_dec,
    output logic [ChW-1:0]    o_ch
);
    import cdmac_pkg::*;

    always_comb begin
        o_dec          = '0;
        o_dec.reg_sel  = CR_NONE;
        o_ch           = '0;

        // Channel select on bits 15..8; channels past the build count do not exist
        for (int i = 0; i < NUM_BASES; i++) begin
            if (i < NumChannels && i_addr[15:8] == CHAN_BASE[i]) begin
                o_dec.chan_hit = 1'b1;
                o_ch           = ChW'(i);
            end
        end

        unique case (i_addr[7:0])
            OFS_CONTROL:  o_dec.reg_sel = CR_CONTROL;
            OFS_MEM_ADDR: o_dec.reg_sel = CR_MEM_ADDR;
            OFS_COUNT:    o_dec.reg_sel = CR_COUNT;
            OFS_TAG_PTR:  o_dec.reg_sel = CR_TAG_PTR;
            OFS_STACK0:   o_dec.reg_sel = CR_STACK0;
            OFS_STACK1:   o_dec.reg_sel = CR_STACK1;
            OFS_SPAD:     o_dec.reg_sel = CR_SPAD;
            default:      o_dec.reg_sel = CR_NONE;
        endcase

        for (int g = 0; g < GLOBAL_REGS; g++) begin
            if (i_addr == GLOBAL_ADDR[g]) begin
                o_dec.glob_hit = 1'b1;
                o_dec.glob_idx = 3'(g);
            end
        end

        o_dec.stat_hit = (i_addr == STAT_ADDR);
    end

endmodule

/* sv/cdmac_regfile.sv */
module cdmac_regfile #(
    parameter int unsigned NumChannels = cdmac_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned ChW         = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  cdmac_pkg::t_func  i_func,
    input  cdmac_pkg::t_dec   i_dec,
    input  logic [ChW-1:0]    i_ch,
    input  logic [31:0]       i_wdata,
    input  logic [2:0]        i_tag_id,
    input  logic              i_tag_irq,
    input  logic [31:0]       i_tag_ptr,
    output logic [31:0]       o_rdata,
    output logic              o_tag_end,
    output logic              o_irq
);
    import cdmac_pkg::*;

    logic [31:0] r_control [NumChannels];
    logic [31:0] r_mem     [NumChannels];
    logic [31:0] r_count   [NumChannels];
    logic [31:0] r_tadr    [NumChannels];
    logic [31:0] r_stack0  [NumChannels];
    logic [31:0] r_stack1  [NumChannels];
    logic [31:0] r_spad    [NumChannels];
    logic [31:0] r_glob    [GLOBAL_REGS];
    logic [31:0] r_status;

    logic [31:0] cur_tadr, tadr_inc, mem_wd, tadr_wd, stat_wd, n_status;
    logic        mem_we, tadr_we, creg_we, glob_we, stat_we, tie_irq;

    always_comb begin
        cur_tadr  = r_tadr[i_ch];
        tadr_inc  = cur_tadr + TAG_STEP;
        tie_irq   = r_control[i_ch][TIE_BIT_POS] & i_tag_irq;
        mem_we    = 1'b0;
        mem_wd    = tadr_inc;
        tadr_we   = 1'b0;
        tadr_wd   = tadr_inc;
        creg_we   = 1'b0;
        glob_we   = 1'b0;
        stat_we   = 1'b0;
        o_rdata   = '0;
        o_tag_end = 1'b0;

        // Clear flags written as one, toggle mask bits, take the rest as written
        stat_wd = (((r_status & ~(i_wdata & FLAG_MASK)) ^ (i_wdata & MASK_FIELD))
                   & STAT_KEEP) | (i_wdata & ~STAT_KEEP);

        unique case (i_func)
            FN_READ: begin
                if (i_dec.chan_hit) begin
                    unique case (i_dec.reg_sel)
                        CR_CONTROL:  o_rdata = r_control[i_ch];
                        CR_MEM_ADDR: o_rdata = r_mem[i_ch];
                        CR_COUNT:    o_rdata = r_count[i_ch];
                        CR_TAG_PTR:  o_rdata = cur_tadr;
                        CR_STACK0:   o_rdata = r_stack0[i_ch];
                        CR_STACK1:   o_rdata = r_stack1[i_ch];
                        CR_SPAD:     o_rdata = r_spad[i_ch];
                        CR_NONE:     o_rdata = '0;
                    endcase
                end else if (i_dec.stat_hit) begin
                    o_rdata = r_status;
                end else if (i_dec.glob_hit) begin
                    o_rdata = r_glob[i_dec.glob_idx];
                end
            end
            FN_WRITE: begin
                creg_we = i_dec.chan_hit;
                stat_we = !i_dec.chan_hit && i_dec.stat_hit;
                glob_we = !i_dec.chan_hit && !i_dec.stat_hit && i_dec.glob_hit;
            end
            FN_SRC_TAG: begin
                if (i_dec.chan_hit) begin
                    unique case (i_tag_id)
                        TAG_REF_END: begin
                            mem_we    = 1'b1;
                            mem_wd    = i_tag_ptr;
                            tadr_we   = 1'b1;
                            o_tag_end = 1'b1;
                        end
                        TAG_CNT: begin
                            // both addresses move on past the tag
                            mem_we  = 1'b1;
                            tadr_we = 1'b1;
                        end
                        TAG_NEXT: begin
                            mem_we  = 1'b1;
                            tadr_we = 1'b1;
                            tadr_wd = i_tag_ptr;
                        end
                        TAG_REF: begin
                            mem_we  = 1'b1;
                            mem_wd  = i_tag_ptr;
                            tadr_we = 1'b1;
                        end
                        TAG_END: begin
                            mem_we    = 1'b1;
                            o_tag_end = 1'b1;
                        end
                        default: ;
                    endcase
                    o_tag_end = o_tag_end | tie_irq;
                end
            end
            FN_DST_TAG: begin
                if (i_dec.chan_hit) begin
                    o_tag_end = tie_irq | (i_tag_id == TAG_END);
                    if (i_tag_id == TAG_REF_END || i_tag_id == TAG_CNT ||
                        i_tag_id == TAG_END) begin
                        mem_we = 1'b1;
                        mem_wd = i_tag_ptr;
                    end
                end
            end
        endcase

        n_status = stat_we ? stat_wd : r_status;
        o_irq    = |(n_status[9:0] & n_status[25:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumChannels; i++) begin
                r_control[i] <= '0;
                r_mem[i]     <= '0;
                r_count[i]   <= '0;
                r_tadr[i]    <= '0;
                r_stack0[i]  <= '0;
                r_stack1[i]  <= '0;
                r_spad[i]    <= '0;
            end
            for (int g = 0; g < GLOBAL_REGS; g++) begin
                r_glob[g] <= '0;
            end
            r_status <= '0;
        end else if (i_en) begin
            if (creg_we) begin
                unique case (i_dec.reg_sel)
                    CR_CONTROL:  r_control[i_ch] <= i_wdata;
                    CR_MEM_ADDR: r_mem[i_ch]     <= i_wdata;
                    CR_COUNT:    r_count[i_ch]   <= i_wdata;
                    CR_TAG_PTR:  r_tadr[i_ch]    <= i_wdata;
                    CR_STACK0:   r_stack0[i_ch]  <= i_wdata;
                    CR_STACK1:   r_stack1[i_ch]  <= i_wdata;
                    CR_SPAD:     r_spad[i_ch]    <= i_wdata;
                    CR_NONE:     ;
                endcase
            end
            if (mem_we) begin
                r_mem[i_ch] <= mem_wd;
            end
            if (tadr_we) begin
                r_tadr[i_ch] <= tadr_wd;
            end
            if (glob_we) begin
                r_glob[i_dec.glob_idx] <= i_wdata;
            end
            r_status <= n_status;
        end
    end

endmodule

/* sv/chained_dma_controller_registers.sv */
// Register block of a chained DMA controller, seen from the register bus and the tag decoder.
// Input channel (i_s_*): one transfer per bus read, bus write or decoded chain tag.
//   tuser carries the function: read, write, source tag or destination tag.
// Output channel (o_m_*): exactly one transfer per input transfer, in order, carrying
//   the read data and the interrupt line as seen after the update; tlast is high when
//   a tag ends the chain.
// Path: a transfer is taken into the input register, decoded and applied to the register
//   file from there, and its result is captured in the output register when the pipe
//   advances.
// Throughput: one transfer per cycle while the receiver does not stall. The register file
//   update and its read share the single pass between the input and output registers, so
//   each item sees all the updates of the items before it.
// Reset (synchronous, active low) clears every channel, global and status register to
//   zero and empties both pipeline registers.
// When the receiver stalls, the output register holds its result, the input register
//   holds its item, and o_s_tready drops once both are full; nothing is lost or repeated.
module chained_dma_controller_registers #(
    parameter int unsigned NumChannels = cdmac_pkg::NUM_CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] addr, [63:32] wdata, [66:64] tag_id, [67] tag_irq, [99:68] tag_ptr, [103:100] zero
    input  logic [103:0] i_s_tdata,
    // [1:0] func
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] rdata, [32] irq_line, [39:33] zero
    output logic [39:0]  o_m_tdata,
    // tag_end
    output logic         o_m_tlast
);
    import cdmac_pkg::*;

    localparam int unsigned ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

    // input register
    logic        r_s1_valid;
    t_func       r_func;
    logic [31:0] r_addr, r_wdata, r_tag_ptr;
    logic [2:0]  r_tag_id;
    logic        r_tag_irq;

    // output register
    logic        r_m_valid;
    logic [31:0] r_m_rdata;
    logic        r_m_end, r_m_irq;

    logic        advance, accept, commit;
    t_dec        dec;
    logic [ChW-1:0] ch;
    logic [31:0] n_rdata;
    logic        n_end, n_irq;

    // Advance the pipe whenever the output register is free or being drained
    assign advance    = !r_m_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || advance;
    assign accept     = i_s_tvalid && o_s_tready;
    assign commit     = r_s1_valid && advance;

    cdmac_decode #(
        .NumChannels(NumChannels),
        .ChW        (ChW)
    ) u_decode (
        .i_addr(r_addr),
        .o_dec (dec),
        .o_ch  (ch)
    );

    cdmac_regfile #(
        .NumChannels(NumChannels),
        .ChW        (ChW)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (commit),
        .i_func    (r_func),
        .i_dec     (dec),
        .i_ch      (ch),
        .i_wdata   (r_wdata),
        .i_tag_id  (r_tag_id),
        .i_tag_irq (r_tag_irq),
        .i_tag_ptr (r_tag_ptr),
        .o_rdata   (n_rdata),
        .o_tag_end (n_end),
        .o_irq     (n_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_m_valid <= r_s1_valid;
            end
        end
    end

    // Payload: input side captured on accept, output side on commit, held otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= t_func'(i_s_tuser);
            r_addr    <= i_s_tdata[31:0];
            r_wdata   <= i_s_tdata[63:32];
            r_tag_id  <= i_s_tdata[66:64];
            r_tag_irq <= i_s_tdata[67];
            r_tag_ptr <= i_s_tdata[99:68];
        end
        if (commit) begin
            r_m_rdata <= n_rdata;
            r_m_end   <= n_end;
            r_m_irq   <= n_irq;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'b0, r_m_irq, r_m_rdata};
    assign o_m_tlast  = r_m_end;

endmodule

/* sim/tb_chained_dma_controller_registers.sv */
`timescale 1ns / 1ps

module tb_chained_dma_controller_registers;
    import cdmac_pkg::*;

    localparam int NUM_CH       = NUM_CHANNELS_DEF;
    localparam int RAND_ITEMS   = 1600;
    // Idle cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // Length of the one long hold-off on the result side
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [7:0] CHAN_OFS [7] = '{
        OFS_CONTROL, OFS_MEM_ADDR, OFS_COUNT, OFS_TAG_PTR, OFS_STACK0, OFS_STACK1, OFS_SPAD
    };

    // One register access or decoded chain tag
    typedef struct {
        t_func       fn;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [2:0]  tag_id;
        logic        tag_irq;
        logic [31:0] tag_ptr;
    } t_access;

    // What the block returns for one access
    typedef struct {
        logic [31:0] rdata;
        logic        tag_end;
        logic        irq;
    } t_reply;

    // Directed row: the access, and where obvious the reply typed in by hand
    typedef struct {
        t_access acc;
        bit      typed;
        t_reply  rep;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // [31:0] addr, [63:32] wdata, [66:64] tag_id, [67] tag_irq, [99:68] tag_ptr, [103:100] zero
    logic [103:0] i_s_tdata;
    // [1:0] func
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // [31:0] rdata, [32] irq_line, [39:33] zero
    logic [39:0]  o_m_tdata;
    // tag_end
    logic         o_m_tlast;

    // Shadow of the register file, kept in step with every accepted transfer
    logic [31:0] chan_regs [NUM_CH][7];
    logic [31:0] glob_regs [GLOBAL_REGS];
    logic [31:0] stat_word;

    t_reply pending_replies [$];
    t_row   directed_rows [$];
    int     n_errors;
    int     n_replies;
    int     stall_cycles;
    bit     hold_done;

    chained_dma_controller_registers #(
        .NumChannels(NUM_CH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Register decode, as the bus sees it
    // ---------------------------------------------------------------

    // Channel for address bits 15..8, or -1 when none (or beyond the built count)
    function automatic int chan_of(logic [31:0] a);
        for (int i = 0; i < NUM_BASES; i++) begin
            if (a[15:8] == CHAN_BASE[i]) begin
                return (i < NUM_CH) ? i : -1;
            end
        end
        return -1;
    endfunction

    function automatic t_chan_reg reg_of(logic [7:0] ofs);
        case (ofs)
            OFS_CONTROL:  return CR_CONTROL;
            OFS_MEM_ADDR: return CR_MEM_ADDR;
            OFS_COUNT:    return CR_COUNT;
            OFS_TAG_PTR:  return CR_TAG_PTR;
            OFS_STACK0:   return CR_STACK0;
            OFS_STACK1:   return CR_STACK1;
            OFS_SPAD:     return CR_SPAD;
            default:      return CR_NONE;
        endcase
    endfunction

    // Global registers match on the whole address
    function automatic int glob_of(logic [31:0] a);
        for (int i = 0; i < GLOBAL_REGS; i++) begin
            if (a == GLOBAL_ADDR[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    // ---------------------------------------------------------------
    // Predictor: apply one transfer to the shadow and work out its reply
    // ---------------------------------------------------------------
    task automatic predict_reply(input t_access it, output t_reply rp);
        int          ch;
        int          g;
        t_chan_reg   rs;
        logic [31:0] mem;
        logic [31:0] tadr;
        logic        tie;

        rp.rdata   = '0;
        rp.tag_end = 1'b0;
        ch = chan_of(it.addr);

        if (it.fn == FN_READ || it.fn == FN_WRITE) begin
            if (ch >= 0) begin
                // A channel window swallows the address even when the offset is unknown
                rs = reg_of(it.addr[7:0]);
                if (rs != CR_NONE) begin
                    if (it.fn == FN_READ) begin
                        rp.rdata = chan_regs[ch][int'(rs)];
                    end else begin
                        chan_regs[ch][int'(rs)] = it.wdata;
                    end
                end
            end else if (it.addr == STAT_ADDR) begin
                if (it.fn == FN_READ) begin
                    rp.rdata = stat_word;
                end else begin
                    // Clear flags written as one, toggle mask bits, take the rest
                    stat_word = stat_word & ~(it.wdata & FLAG_MASK);
                    stat_word = stat_word ^ (it.wdata & MASK_FIELD);
                    stat_word = (stat_word & STAT_KEEP) | (it.wdata & ~STAT_KEEP);
                end
            end else begin
                g = glob_of(it.addr);
                if (g >= 0) begin
                    if (it.fn == FN_READ) begin
                        rp.rdata = glob_regs[g];
                    end else begin
                        glob_regs[g] = it.wdata;
                    end
                end
            end
        end else if (ch >= 0) begin
            mem  = chan_regs[ch][int'(CR_MEM_ADDR)];
            tadr = chan_regs[ch][int'(CR_TAG_PTR)];
            tie  = chan_regs[ch][int'(CR_CONTROL)][TIE_BIT_POS];
            if (it.fn == FN_SRC_TAG) begin
                // Address arithmetic wraps at 32 bits
                case (it.tag_id)
                    TAG_REF_END: begin
                        mem  = it.tag_ptr;
                        tadr = tadr + TAG_STEP;
                        rp.tag_end = 1'b1;
                    end
                    TAG_CNT: begin
                        mem  = tadr + TAG_STEP;
                        tadr = mem;
                    end
                    TAG_NEXT: begin
                        mem  = tadr + TAG_STEP;
                        tadr = it.tag_ptr;
                    end
                    TAG_REF: begin
                        mem  = it.tag_ptr;
                        tadr = tadr + TAG_STEP;
                    end
                    TAG_END: begin
                        mem  = tadr + TAG_STEP;
                        rp.tag_end = 1'b1;
                    end
                    default: ;
                endcase
                if (tie && it.tag_irq) begin
                    rp.tag_end = 1'b1;
                end
            end else begin
                rp.tag_end = tie && it.tag_irq;
                if (it.tag_id == TAG_END) begin
                    rp.tag_end = 1'b1;
                end
                if (it.tag_id inside {TAG_REF_END, TAG_CNT, TAG_END}) begin
                    mem = it.tag_ptr;
                end
            end
            chan_regs[ch][int'(CR_MEM_ADDR)] = mem;
            chan_regs[ch][int'(CR_TAG_PTR)]  = tadr;
        end

        // Interrupt line follows the status word after the update
        rp.irq = |(stat_word[9:0] & stat_word[25:16]);
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [31:0] pick_addr(bit want_chan, int last_ch);
        int          r;
        int          ch;
        logic [15:0] upper;
        logic [7:0]  ofs;
        r = $urandom_range(99);
        if (want_chan || r < 60) begin
            // Stay on the same channel often, so tag runs build on earlier state
            ch    = ($urandom_range(99) < 60) ? last_ch : $urandom_range(NUM_BASES - 1);
            upper = ($urandom_range(1) != 0) ? 16'($urandom()) : 16'h0000;
            ofs   = ($urandom_range(9) != 0) ? CHAN_OFS[$urandom_range(6)] : 8'($urandom());
            return {upper, CHAN_BASE[ch], ofs};
        end
        if (r < 72) return STAT_ADDR;
        if (r < 88) return GLOBAL_ADDR[$urandom_range(GLOBAL_REGS - 1)];
        return $urandom();
    endfunction

    function automatic t_access make_access(ref int last_ch);
        t_access it;
        int      r;
        r = $urandom_range(99);
        if (r < 30)      it.fn = FN_READ;
        else if (r < 65) it.fn = FN_WRITE;
        else if (r < 85) it.fn = FN_SRC_TAG;
        else             it.fn = FN_DST_TAG;
        it.addr     = pick_addr(it.fn == FN_SRC_TAG || it.fn == FN_DST_TAG
                                ? ($urandom_range(99) < 85) : 1'b0, last_ch);
        if (it.addr[15:8] inside {CHAN_BASE}) begin
            for (int i = 0; i < NUM_BASES; i++) begin
                if (it.addr[15:8] == CHAN_BASE[i]) last_ch = i;
            end
        end
        it.wdata    = $urandom();
        it.tag_id   = 3'($urandom_range(7));
        it.tag_irq  = 1'($urandom_range(1));
        it.tag_ptr  = $urandom();
        return it;
    endfunction

    task automatic add_row(input t_func fn, input logic [31:0] addr, input logic [31:0] wdata,
                           input logic [2:0] id, input logic irq, input logic [31:0] tptr,
                           input bit typed, input logic [31:0] rd, input logic te);
        t_row row;
        row.acc   = '{fn: fn, addr: addr, wdata: wdata, tag_id: id, tag_irq: irq,
                      tag_ptr: tptr};
        row.typed = typed;
        row.rep   = '{rdata: rd, tag_end: te, irq: 1'b0};
        directed_rows.push_back(row);
    endtask

    // Offer one transfer after an optional gap and hold it until taken; the
    // reply is predicted at the edge that takes it. Return at the next falling
    // edge with tvalid still high, so back-to-back transfers never drop it.
    task automatic send_access(input t_access it, input int gap, input bit typed,
                               input t_reply typed_rep);
        t_reply rp;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {4'b0, it.tag_ptr, it.tag_irq, it.tag_id, it.wdata, it.addr};
        i_s_tuser  = it.fn;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_reply(it, rp);
        pending_replies.push_back(typed ? typed_rep : rp);
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Sender: reset, directed table, then random traffic
    // ---------------------------------------------------------------
    initial begin
        t_access it;
        t_reply  none;
        int      last_ch;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = FN_READ;
        none       = '{rdata: '0, tag_end: 1'b0, irq: 1'b0};
        last_ch    = 0;
        stat_word  = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int k = 0; k < 7; k++) chan_regs[c][k] = '0;
        end
        for (int k = 0; k < GLOBAL_REGS; k++) glob_regs[k] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Everything reads as zero after reset, unknown addresses included
        add_row(FN_READ,  32'h0000_8000, '0, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  STAT_ADDR,     '0, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  32'hFFFF_FFFF, '0, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        // Set TIE on channel 0
        add_row(FN_WRITE, 32'h0000_8000, 32'h0000_0080, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        // Status write with all ones: mask toggles on, upper bits taken, flags stay clear
        add_row(FN_WRITE, STAT_ADDR, 32'hFFFF_FFFF, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  STAT_ADDR, '0, '0, 1'b0, '0, 1, 32'hFFFF_FC00, 1'b0);
        // Toggle the mask back off and clear the upper bits
        add_row(FN_WRITE, STAT_ADDR, 32'h03FF_03FF, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  STAT_ADDR, '0, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        // Last channel, all-ones data
        add_row(FN_WRITE, 32'h0000_D410, 32'hFFFF_FFFF, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  32'h0000_D410, '0, '0, 1'b0, '0, 1, 32'hFFFF_FFFF, 1'b0);
        add_row(FN_WRITE, 32'h1000_F590, 32'hA5A5_A5A5, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  32'h1000_F590, '0, '0, 1'b0, '0, 1, 32'hA5A5_A5A5, 1'b0);
        // Tag address near the top, so the next tag wraps past zero
        add_row(FN_WRITE, 32'h0000_8030, 32'hFFFF_FFF8, '0, 1'b0, '0, 1, 32'h0, 1'b0);
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, TAG_CNT, 1'b0, '0, 0, '0, 1'b0);
        add_row(FN_READ,  32'h0000_8010, '0, '0, 1'b0, '0, 0, '0, 1'b0);
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, TAG_REF_END, 1'b0, 32'h1234_5678,
                1, 32'h0, 1'b1);
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, TAG_NEXT, 1'b0, 32'hFFFF_FFF0, 0, '0, 1'b0);
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, TAG_REF, 1'b0, 32'h0, 0, '0, 1'b0);
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, TAG_END, 1'b0, 32'h0, 0, '0, 1'b0);
        // Unused id on a TIE channel with the irq bit still ends the chain
        add_row(FN_SRC_TAG, 32'h0000_8000, '0, 3'd5, 1'b1, 32'h0, 1, 32'h0, 1'b1);
        add_row(FN_DST_TAG, 32'h0000_9000, '0, TAG_END, 1'b0, 32'h5555_5555, 1, 32'h0, 1'b1);
        // Destination tag looks at its own channel's TIE, clear on channel 1
        add_row(FN_DST_TAG, 32'h0000_9000, '0, TAG_NEXT, 1'b1, 32'h0, 1, 32'h0, 1'b0);
        add_row(FN_DST_TAG, 32'h0000_8000, '0, TAG_CNT, 1'b1, 32'hAAAA_AAAA, 1, 32'h0, 1'b1);
        // Tag with no channel behind its address
        add_row(FN_SRC_TAG, STAT_ADDR, '0, TAG_REF_END, 1'b1, 32'h0, 1, 32'h0, 1'b0);
        add_row(FN_READ,  32'h0000_8004, '0, '0, 1'b0, '0, 1, 32'h0, 1'b0);

        foreach (directed_rows[i]) begin
            send_access(directed_rows[i].acc, idle_len(1'b0), directed_rows[i].typed,
                        directed_rows[i].rep);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            it = make_access(last_ch);
            send_access(it, idle_len(((n / 150) % 4) == 2), 1'b0, none);
        end
        i_s_tvalid = 1'b0;

        // Drain, then wait out the tail so that anything spurious can show
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off so the block fills
    // ---------------------------------------------------------------
    initial begin
        int g;
        i_m_tready = 1'b0;
        hold_done  = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!hold_done && n_replies >= 80) begin
                hold_done  = 1'b1;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            g = idle_len(((n_replies / 150) % 4) == 3);
            if (g > 0) begin
                i_m_tready = 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Checker: compare each result transfer with the oldest prediction
    // ---------------------------------------------------------------
    initial begin
        n_errors  = 0;
        n_replies = 0;
    end

    always @(posedge i_clk) begin
        t_reply exp_rep;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_replies++;
            if (pending_replies.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result transfer rdata %h tlast %b irq %b",
                         $realtime, o_m_tdata[31:0], o_m_tlast, o_m_tdata[32]);
            end else begin
                exp_rep = pending_replies.pop_front();
                if (o_m_tdata[31:0] !== exp_rep.rdata) begin
                    n_errors++;
                    $display("%0t: rdata expected %h actual %h",
                             $realtime, exp_rep.rdata, o_m_tdata[31:0]);
                end
                if (o_m_tlast !== exp_rep.tag_end) begin
                    n_errors++;
                    $display("%0t: tag_end expected %b actual %b",
                             $realtime, exp_rep.tag_end, o_m_tlast);
                end
                if (o_m_tdata[32] !== exp_rep.irq) begin
                    n_errors++;
                    $display("%0t: irq_line expected %b actual %b",
                             $realtime, exp_rep.irq, o_m_tdata[32]);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, pending_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial stall_cycles = 0;

endmodule
